// File: sv/xpfr_pkg.sv
// xpfr_pkg: shared constants for the xor parity fragment recovery block
// no dependencies
package xpfr_pkg;
  localparam int unsigned SLOTS        = 16;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned MAX_WORDS    = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned WORD_W  = 3;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = SLOT_W + CH_W + WORD_W;
  localparam int unsigned DEPTH   = SLOTS * MAX_CHANNELS * MAX_WORDS;
  localparam logic [0:0] REG_CHANNEL_COUNT  = 1'b0;
  localparam logic [0:0] REG_FRAGMENT_WORDS = 1'b1;
endpackage

// File: sv/xpfr_ram.sv
// xpfr_ram: generic single port synchronous ram with registered read
// no dependencies
module xpfr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: sv/xor_parity_fragment_recovery_top.sv
// xor_parity_fragment_recovery_top: top level of the fragment recovery block
// depends on xpfr_pkg and xpfr_ram
//
// Fragment words are written into a 1024 x 64 store, one request per cycle of
// acceptance while idle (after a final word the slot's received map is checked
// in S_CHECK, where no request is taken). When a final word leaves exactly
// one data fragment missing with parity present, the block rebuilds that
// fragment through the single store port: per word it reads every other
// channel (channel_count-1 reads, one per cycle) and then writes the XOR
// back. It then reads out each data word, issuing each read in S_ERD and
// capturing it into the output register in S_EOUT, which waits while the
// output is stalled. While rebuilding or emitting no input
// request is taken. Out of range requests are dropped. Received bits persist
// until reset; the store is not cleared.
module xor_parity_fragment_recovery_top import xpfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [SLOT_W-1:0] request_slot_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [WORD_W-1:0] word_index_i,
  input  logic [DATA_W-1:0] data_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic [CH_W-1:0]   out_channel_o,
  output logic [WORD_W-1:0] out_word_index_o,
  output logic [DATA_W-1:0] out_data_o,
  output logic              out_last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [3:0]        cfg_data_i
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RRD   = 3'd2; // rebuild read issue
  localparam logic [2:0] S_RWB   = 3'd3; // rebuild write back
  localparam logic [2:0] S_ERD   = 3'd4; // emit read issue
  localparam logic [2:0] S_EOUT  = 3'd5; // emit capture

  logic [2:0] state_q;
  logic [3:0] cc_q, fw_q;
  logic [MAX_CHANNELS-1:0] rmap_q [SLOTS];
  logic [SLOT_W-1:0] slot_q;
  logic [CH_W-1:0]   miss_q, ch_q;
  logic [WORD_W-1:0] wd_q;
  logic              rd_pend_q;
  logic [DATA_W-1:0] acc_q;

  // effective register values
  logic [3:0] cc_eff, fw_eff;
  always_comb begin
    cc_eff = (cc_q < 4'd2) ? 4'd2 : ((cc_q > 4'd8) ? 4'd8 : cc_q);
    fw_eff = (fw_q == 4'd0) ? 4'd1 : ((fw_q > 4'd8) ? 4'd8 : fw_q);
  end
  logic [CH_W-1:0]   par_ch;
  logic [WORD_W-1:0] last_w;
  assign par_ch = 3'(cc_eff - 4'd1);
  assign last_w = 3'(fw_eff - 4'd1);

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 4'd2;
      fw_q <= 4'd8;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_CHANNEL_COUNT) cc_q <= cfg_data_i;
      else fw_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  logic in_acc, in_ok;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ok = ({1'b0, channel_i} < cc_eff) && ({1'b0, word_index_i} < fw_eff);

  // slot check on the registered map
  logic [MAX_CHANNELS-1:0] m;
  logic [3:0] have;
  logic found;
  logic [CH_W-1:0] first_miss;
  always_comb begin
    m = rmap_q[slot_q];
    have = '0;
    found = 1'b0;
    first_miss = '0;
    for (int i = 0; i < MAX_CHANNELS - 1; i++) begin
      if (3'(i) < par_ch) begin
        if (m[i]) have = have + 4'd1;
        else if (!found) begin
          found = 1'b1;
          first_miss = 3'(i);
        end
      end
    end
  end
  logic go;
  assign go = found && (have == cc_eff - 4'd2) && m[par_ch];

  // output register
  logic out_busy;
  logic out_load;
  assign out_busy = out_valid_o && !out_ready_i;
  assign out_load = (state_q == S_EOUT) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // ram port
  logic              we;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata, rdata;
  always_comb begin
    we = 1'b0;
    addr = {slot_q, ch_q, wd_q};
    wdata = acc_q ^ rdata;
    case (state_q)
      S_IDLE: begin
        we = in_acc && in_ok;
        addr = {request_slot_i, channel_i, word_index_i};
        wdata = data_word_i;
      end
      S_RWB: begin
        we = 1'b1;
        addr = {slot_q, miss_q, wd_q};
      end
      default: ;
    endcase
  end

  xpfr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // next channel to read in rebuild, skipping the missing one
  logic [CH_W-1:0] nxt_ch;
  logic nxt_end;
  always_comb begin
    nxt_ch = ch_q + 3'd1;
    if (nxt_ch == miss_q) nxt_ch = nxt_ch + 3'd1;
    nxt_end = ({1'b0, ch_q} + 4'd1 == cc_eff) ||
              (({1'b0, ch_q} + 4'd2 == cc_eff) && (ch_q + 3'd1 == miss_q));
  end
  logic [CH_W-1:0] first_rd;
  assign first_rd = (miss_q == 3'd0) ? 3'd1 : 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_pend_q <= 1'b0;
      for (int s = 0; s < SLOTS; s++) rmap_q[s] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_ok && word_index_i == last_w) begin
            rmap_q[request_slot_i][channel_i] <= 1'b1;
            slot_q <= request_slot_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          miss_q <= first_miss;
          wd_q <= '0;
          acc_q <= '0;
          rd_pend_q <= 1'b0;
          ch_q <= (first_miss == 3'd0) ? 3'd1 : 3'd0;
          state_q <= go ? S_RRD : S_IDLE;
        end
        S_RRD: begin
          // accumulate data of the previous read, issue the next channel
          if (rd_pend_q) acc_q <= acc_q ^ rdata;
          ch_q <= nxt_ch;
          if (nxt_end) begin
            rd_pend_q <= 1'b0;
            state_q <= S_RWB;
          end else begin
            rd_pend_q <= 1'b1;
          end
        end
        S_RWB: begin
          acc_q <= '0;
          if (wd_q == last_w) begin
            wd_q <= '0;
            ch_q <= '0;
            state_q <= S_ERD;
          end else begin
            ch_q <= first_rd;
            wd_q <= wd_q + 3'd1;
            state_q <= S_RRD;
          end
        end
        S_ERD: begin
          state_q <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_busy) begin
            out_slot_o <= slot_q;
            out_channel_o <= ch_q;
            out_word_index_o <= wd_q;
            out_data_o <= rdata;
            out_last_o <= (ch_q + 3'd1 == par_ch) && (wd_q == last_w);
            if (wd_q == last_w) begin
              wd_q <= '0;
              ch_q <= ch_q + 3'd1;
              state_q <= (ch_q + 3'd1 == par_ch) ? S_IDLE : S_ERD;
            end else begin
              wd_q <= wd_q + 3'd1;
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for the xor parity fragment recovery block
// depends on xpfr_pkg and xor_parity_fragment_recovery_top
module testbench;
  import xpfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   ch;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] data;
  } frag_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CH_W-1:0]   ch;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] data;
    logic              last;
  } merged_word_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [CH_W-1:0]   in_ch = '0;
  logic [WORD_W-1:0] in_word = '0;
  logic [DATA_W-1:0] in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic [CH_W-1:0]   out_ch;
  logic [WORD_W-1:0] out_word;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = REG_CHANNEL_COUNT;
  logic [3:0]        cfg_data = '0;

  // shadow of the block: store, written marks, received maps, configuration
  logic [DATA_W-1:0]       frag_mem [DEPTH];
  bit                      written_mem [DEPTH];
  logic [MAX_CHANNELS-1:0] got_map [SLOTS];
  int unsigned             eff_cc = 2;
  int unsigned             eff_fw = 8;

  frag_word_t   pending_q[$];
  merged_word_t merged_q[$];

  idle_mode_t idle_mode = IDLE_NONE;
  bit         in_fire = 1'b0;
  bit         pressure_arm = 1'b0;
  bit         pressure_done = 1'b0;
  int         hold_left = 0;
  int         err_cnt = 0;
  int         sent_cnt = 0;
  int         merged_cnt = 0;
  int         rebuild_cnt = 0;
  int         cycle_cnt = 0;

  xor_parity_fragment_recovery_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .request_slot_i   (in_slot),
    .channel_i        (in_ch),
    .word_index_i     (in_word),
    .data_word_i      (in_data),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_slot_o       (out_slot),
    .out_channel_o    (out_ch),
    .out_word_index_o (out_word),
    .out_data_o       (out_data),
    .out_last_o       (out_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned addr_of(int unsigned slot, int unsigned ch, int unsigned w);
    return (slot * MAX_CHANNELS + ch) * MAX_WORDS + w;
  endfunction

  // true when this request would start a rebuild that reads a never written word
  function automatic bit reads_unwritten(frag_word_t it);
    logic [MAX_CHANNELS-1:0] map;
    int unsigned             have;
    int unsigned             miss;
    bit                      found;
    int unsigned             a;
    map   = got_map[it.slot];
    have  = 0;
    miss  = 0;
    found = 1'b0;
    if (it.ch >= eff_cc || it.word >= eff_fw || it.word != eff_fw - 1) return 1'b0;
    map[it.ch] = 1'b1;
    for (int unsigned i = 0; i < eff_cc - 1; i++) begin
      if (map[i]) have++;
      else if (!found) begin
        miss  = i;
        found = 1'b1;
      end
    end
    if (!found || have != eff_cc - 2 || !map[eff_cc-1]) return 1'b0;
    for (int unsigned k = 0; k < eff_fw; k++) begin
      for (int unsigned i = 0; i < eff_cc; i++) begin
        a = addr_of(it.slot, i, k);
        if (i != miss && !written_mem[a] && a != addr_of(it.slot, it.ch, it.word))
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // store the word, and on a final word rebuild and queue the merged request
  function automatic void recover_step(frag_word_t it);
    int unsigned       have;
    int unsigned       miss;
    bit                found;
    logic [DATA_W-1:0] acc;
    merged_word_t      mw;
    have  = 0;
    miss  = 0;
    found = 1'b0;
    if (it.ch >= eff_cc || it.word >= eff_fw) return;
    frag_mem[addr_of(it.slot, it.ch, it.word)]    = it.data;
    written_mem[addr_of(it.slot, it.ch, it.word)] = 1'b1;
    if (it.word != eff_fw - 1) return;
    got_map[it.slot][it.ch] = 1'b1;
    for (int unsigned i = 0; i < eff_cc - 1; i++) begin
      if (got_map[it.slot][i]) have++;
      else if (!found) begin
        miss  = i;
        found = 1'b1;
      end
    end
    if (!found || have != eff_cc - 2 || !got_map[it.slot][eff_cc-1]) return;
    rebuild_cnt++;
    for (int unsigned k = 0; k < eff_fw; k++) begin
      acc = '0;
      for (int unsigned i = 0; i < eff_cc; i++)
        if (i != miss) acc ^= frag_mem[addr_of(it.slot, i, k)];
      frag_mem[addr_of(it.slot, miss, k)]    = acc;
      written_mem[addr_of(it.slot, miss, k)] = 1'b1;
    end
    for (int unsigned i = 0; i < eff_cc - 1; i++) begin
      for (int unsigned k = 0; k < eff_fw; k++) begin
        mw.slot = it.slot;
        mw.ch   = CH_W'(i);
        mw.word = WORD_W'(k);
        mw.data = frag_mem[addr_of(it.slot, i, k)];
        mw.last = (i == eff_cc - 2 && k == eff_fw - 1);
        merged_q.push_back(mw);
      end
    end
  endfunction

  // queue one request; a final word that would read unwritten data is turned
  // into a harmless non-final or dropped word
  function automatic void queue_word(frag_word_t it);
    if (reads_unwritten(it)) begin
      if (eff_fw > 1) it.word = WORD_W'(0);
      else it.word = WORD_W'(1);
    end
    recover_step(it);
    pending_q.push_back(it);
    sent_cnt++;
  endfunction

  function automatic frag_word_t make_word(int unsigned slot, int unsigned ch, int unsigned w);
    frag_word_t it;
    it.slot = SLOT_W'(slot);
    it.ch   = CH_W'(ch);
    it.word = WORD_W'(w);
    it.data = {$urandom, $urandom};
    return it;
  endfunction

  // one request sequence for a slot: all but the first missing data channel,
  // sometimes with that channel too (nothing to rebuild) or two left out
  function automatic int gen_sequence();
    int unsigned slot;
    int unsigned skip_a;
    int unsigned skip_b;
    int          kind;
    int          n;
    slot   = $urandom_range(0, SLOTS - 1);
    kind   = $urandom_range(0, 9);
    skip_a = eff_cc;
    skip_b = eff_cc;
    n      = 0;
    for (int unsigned i = 0; i < eff_cc - 1; i++)
      if (!got_map[slot][i] && skip_a == eff_cc) skip_a = i;
    if (kind == 0) skip_a = eff_cc;
    if (kind == 1 && eff_cc > 2) skip_b = (skip_a + 1) % (eff_cc - 1);
    for (int unsigned i = 0; i < eff_cc; i++)
      for (int unsigned k = 0; k + 1 < eff_fw; k++) begin
        queue_word(make_word(slot, i, k));
        n++;
      end
    for (int unsigned i = 0; i < eff_cc; i++)
      if (i != skip_a && i != skip_b) begin
        queue_word(make_word(slot, i, eff_fw - 1));
        n++;
      end
    return n;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CHANNEL_COUNT)
      eff_cc = (val < 2) ? 2 : (val > MAX_CHANNELS) ? MAX_CHANNELS : val;
    else
      eff_fw = (val < 1) ? 1 : (val > MAX_WORDS) ? MAX_WORDS : val;
  endtask

  // wait until every request is in and every merged word out, then let the
  // block finish any work that produces nothing
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || merged_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic bit coin(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // request driver, changes at the falling edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk) begin
    frag_word_t nxt;
    bit         idle;
    idle = (idle_mode == IDLE_SENDER && coin(79)) || (idle_mode == IDLE_BOTH && coin(25));
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_q.size() != 0 && !idle) begin
        nxt = pending_q.pop_front();
        in_slot  <= nxt.slot;
        in_ch    <= nxt.ch;
        in_word  <= nxt.word;
        in_data  <= nxt.data;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off once so the block backs up
  always @(negedge clk) begin
    bit stall;
    stall = (idle_mode == IDLE_RECEIVER && coin(79)) || (idle_mode == IDLE_BOTH && coin(25));
    if (pressure_arm && !pressure_done) begin
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
      out_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && !stall;
    end
  end

  // result checker
  always @(posedge clk) begin
    merged_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (merged_q.size() == 0) begin
        $error("unexpected merged word slot %0d channel %0d word %0d", out_slot, out_ch, out_word);
        err_cnt++;
      end else begin
        exp_w = merged_q.pop_front();
        merged_cnt++;
        if (out_slot !== exp_w.slot) begin
          $error("out_slot expected %0d actual %0d", exp_w.slot, out_slot);
          err_cnt++;
        end
        if (out_ch !== exp_w.ch) begin
          $error("out_channel expected %0d actual %0d", exp_w.ch, out_ch);
          err_cnt++;
        end
        if (out_word !== exp_w.word) begin
          $error("out_word_index expected %0d actual %0d", exp_w.word, out_word);
          err_cnt++;
        end
        if (out_data !== exp_w.data) begin
          $error("out_data expected %h actual %h", exp_w.data, out_data);
          err_cnt++;
        end
        if (out_last !== exp_w.last) begin
          $error("out_last expected %0d actual %0d", exp_w.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // phase list: register values (extremes included) and idling mode
  int unsigned cc_vals [7] = '{0, 3, 4, 5, 6, 7, 15};
  int unsigned fw_vals [7] = '{0, 15, 2, 3, 1, 2, 15};

  initial begin
    int n;
    foreach (got_map[s]) got_map[s] = '0;
    foreach (written_mem[a]) begin
      written_mem[a] = 1'b0;
      frag_mem[a]    = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_CHANNEL_COUNT, cc_vals[p]);
      write_reg(REG_FRAGMENT_WORDS, fw_vals[p]);
      idle_mode = idle_mode_t'(p % 4);
      n = 0;
      if (p == 0) begin
        // directed: two channels of one word each
        queue_word(make_word(3, 7, 0));            // channel beyond count
        queue_word(make_word(3, 0, 5));            // word beyond length
        queue_word('{slot: 0, ch: 1, word: 0, data: '1});  // parity alone, rebuild ch 0
        queue_word('{slot: 1, ch: 0, word: 0, data: '0});
        queue_word(make_word(1, 1, 0));            // all data present
        queue_word('{slot: 2, ch: 1, word: 0, data: 64'h8000_0000_0000_0001});
        queue_word(make_word(2, 1, 0));            // rebuild again on the same slot
        queue_word(make_word(15, 1, 0));
      end
      if (p == 5) pressure_arm = 1'b1;
      while (n < 22) begin
        if (coin(80)) begin
          n += gen_sequence();
        end else begin
          queue_word(make_word($urandom_range(0, SLOTS - 1), $urandom_range(0, 7),
                               $urandom_range(0, 7)));
          n++;
        end
      end
      wait_quiet();
    end

    $display("sent %0d fragment words over 7 register settings, %0d rebuilds",
             sent_cnt, rebuild_cnt);
    $display("checked %0d merged words under four idling modes and one long hold-off",
             merged_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
